// ----- design/bkd_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded knapsack DP package
// Shared widths, payload types and the command and status structs that join
// the controller to the datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bkd_pkg;

  // Table geometry: one entry per capacity from zero to the largest capacity.
  localparam int MAX_CAPACITY = 1023;
  localparam int DEPTH        = MAX_CAPACITY + 1;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int DATA_W       = 32;

  // Field widths of one request.
  localparam int COST_W = 10;
  localparam int VAL_W  = 16;
  localparam int CNT_W  = 8;

  // Chunk cost and chunk value products.
  localparam int DIST_W = COST_W + CNT_W;
  localparam int ADD_W  = VAL_W + CNT_W;

  // Capacity register after reset.
  localparam logic [ADDR_W-1:0] CAP_RESET = ADDR_W'(20);

  // One input request.
  typedef struct packed {
    logic              start_new;
    logic [COST_W-1:0] item_cost;
    logic [VAL_W-1:0]  item_value;
    logic [CNT_W-1:0]  item_count;
  } in_req_t;

  // One result.
  typedef struct packed {
    logic [DATA_W-1:0] best_value;
    logic              took_unlimited;
  } out_res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic clear_init;
    logic clear_step;
    logic plan;
    logic setup;
    logic sweep_init;
    logic sweep_rd;
    logic sweep_wr;
    logic chunk_next;
    logic res_rd;
    logic res_ld;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic req_start;
    logic clear_done;
    logic chunk_skip;
    logic sweep_done;
    logic chunk_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/bounded_knapsack_dp_top.sv -----
// ----------------------------------------------------------------------------
// Bounded knapsack DP, top level
// Input request: one item kind (cost, value, count, start flag). Output
// request: best value at full capacity and the unlimited flag.
//
// Both channels use valid and stall; a request moves on a rising edge with
// valid high and stall low. The capacity register is written through
// cfg_we_i / cfg_wdata_i and resets to 20. The user must write it only
// while the block is idle; the block itself does not enforce this.
// After reset the block runs a clearing pass over the value table with
// in_stall_o high; a request with start_new set runs the same pass before
// its own work. A pass visits at most the capacity plus one table entries,
// none for a chunk that does not fit. Each entry is handled as a read of the
// two table entries, then the saturating add, compare and write-back on the
// single write port. A count splits into at most eight passes. One request
// is worked on at a time. The result waits in an output register; while the
// receiver stalls, the next request is still accepted and processed, and its
// result is held back until it is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_knapsack_dp_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire bkd_pkg::in_req_t           in_req_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output bkd_pkg::out_res_t               out_res_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [bkd_pkg::ADDR_W-1:0] cfg_wdata_i
);

  bkd_pkg::ctrl_cmd_t  cmd;
  bkd_pkg::dp_status_t status;

  // Sequencer.
  bkd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .status_i   (status),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // Table, chunk arithmetic and result register.
  bkd_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o)
  );

endmodule

`default_nettype wire

// ----- design/bkd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bkd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic      [WIDTH-1:0]         rdata_a_o,
  output logic      [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

`default_nettype wire

// ----- design/bkd_datapath.sv -----
// ----------------------------------------------------------------------------
// Bounded knapsack datapath
// Holds the request, the capacity register, chunk bookkeeping, the value
// table and the result register; acts on commands from the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bkd_datapath (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bkd_pkg::in_req_t             in_req_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [bkd_pkg::ADDR_W-1:0]   cfg_wdata_i,
  input  wire logic                         out_stall_i,
  input  wire bkd_pkg::ctrl_cmd_t           cmd_i,
  output bkd_pkg::dp_status_t               status_o,
  output logic                              out_valid_o,
  output bkd_pkg::out_res_t                 out_res_o
);

  localparam int AW = bkd_pkg::ADDR_W;
  localparam int DW = bkd_pkg::DATA_W;

  logic [AW-1:0]              cfg_cap_q;
  logic [AW-1:0]              cap_q;
  logic [bkd_pkg::COST_W-1:0] cost_q;
  logic [bkd_pkg::VAL_W-1:0]  val_q;
  logic [bkd_pkg::CNT_W-1:0]  cnt_q;
  logic                       unlim_q;
  logic [bkd_pkg::CNT_W-1:0]  k_q;
  logic [bkd_pkg::CNT_W-1:0]  left_q;
  logic [bkd_pkg::CNT_W-1:0]  ksz;
  logic [bkd_pkg::DIST_W-1:0] dist_q;
  logic [bkd_pkg::ADD_W-1:0]  add_q;
  logic                       last_q;
  logic [AW-1:0]              v_q;
  logic [AW-1:0]              v_d;
  logic                       out_valid_q;
  bkd_pkg::out_res_t          out_res_q;

  logic [AW-1:0]              dist_lo;
  logic                       k_below;
  logic [bkd_pkg::DIST_W-1:0] total_cost;
  logic [DW:0]                sum;
  logic [DW-1:0]              cand;
  logic                       ram_we;
  logic [DW-1:0]              ram_wdata;
  logic [AW-1:0]              raddr_a;
  logic [AW-1:0]              raddr_b;
  logic [DW-1:0]              rdata_a;
  logic [DW-1:0]              rdata_b;
  logic                       sweep_done;
  logic                       out_free;

  // Capacity register, written by the configuration port.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cap_q <= bkd_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cfg_cap_q <= cfg_wdata_i;
    end
  end

  // Request capture; the capacity is frozen for the whole request.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      cost_q <= in_req_i.item_cost;
      val_q  <= in_req_i.item_value;
      cnt_q  <= in_req_i.item_count;
      cap_q  <= cfg_cap_q;
    end
  end

  // An item is unlimited when all its units together reach the capacity.
  assign total_cost = bkd_pkg::DIST_W'(cost_q) * bkd_pkg::DIST_W'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.plan) begin
      unlim_q <= (total_cost >= bkd_pkg::DIST_W'(cap_q));
    end
  end

  // Binary splitting: chunk k while k is below what is left, then the rest.
  assign k_below = (k_q < left_q);
  assign ksz     = unlim_q ? bkd_pkg::CNT_W'(1) : (k_below ? k_q : left_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.plan) begin
      k_q    <= bkd_pkg::CNT_W'(1);
      left_q <= cnt_q;
    end else if (cmd_i.chunk_next) begin
      left_q <= left_q - k_q;
      k_q    <= k_q << 1;
    end
  end

  // Chunk cost and value, registered before they are used in the sweep.
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      dist_q <= bkd_pkg::DIST_W'(cost_q) * bkd_pkg::DIST_W'(ksz);
      add_q  <= bkd_pkg::ADD_W'(val_q) * bkd_pkg::ADD_W'(ksz);
      last_q <= unlim_q | ~k_below;
    end
  end

  assign dist_lo = dist_q[AW-1:0];

  // The unlimited pass walks upwards, a bounded pass walks downwards.
  assign sweep_done = unlim_q ? (v_q == cap_q) : (v_q == dist_lo);

  // Table address counter, shared by the clearing pass and the sweeps.
  always_comb begin
    v_d = v_q;
    if (cmd_i.clear_init) begin
      v_d = '0;
    end else if (cmd_i.clear_step) begin
      v_d = v_q + AW'(1);
    end else if (cmd_i.sweep_init) begin
      v_d = unlim_q ? dist_lo : cap_q;
    end else if (cmd_i.sweep_wr && !sweep_done) begin
      v_d = unlim_q ? (v_q + AW'(1)) : (v_q - AW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  // Saturating candidate and update of the table entry.
  assign sum  = {1'b0, rdata_a} + (DW + 1)'(add_q);
  assign cand = sum[DW] ? '1 : sum[DW-1:0];

  assign ram_we    = cmd_i.clear_step | (cmd_i.sweep_wr & (cand > rdata_b));
  assign ram_wdata = cmd_i.clear_step ? '0 : cand;
  assign raddr_a   = v_q - dist_lo;
  assign raddr_b   = cmd_i.res_rd ? cap_q : v_q;

  bkd_ram #(
    .WIDTH (DW),
    .DEPTH (bkd_pkg::DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (v_q),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Result register, free once its request is taken.
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_ld) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_ld) begin
      out_res_q.best_value     <= rdata_b;
      out_res_q.took_unlimited <= unlim_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

  // Status back to the controller.
  assign status_o.req_start  = in_req_i.start_new;
  assign status_o.clear_done = (v_q == AW'(bkd_pkg::DEPTH - 1));
  assign status_o.chunk_skip = (dist_q > bkd_pkg::DIST_W'(cap_q));
  assign status_o.sweep_done = sweep_done;
  assign status_o.chunk_last = last_q;
  assign status_o.out_free   = out_free;

endmodule

`default_nettype wire

// ----- design/bkd_ctrl.sv -----
// ----------------------------------------------------------------------------
// Bounded knapsack controller
// Sequences the clearing pass, the chunk passes and the result hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bkd_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  input  wire bkd_pkg::dp_status_t status_i,
  output logic                     in_stall_o,
  output bkd_pkg::ctrl_cmd_t       cmd_o
);

  typedef enum logic [10:0] {
    S_INIT  = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_CLEAR = 11'b000_0000_0100,
    S_PLAN  = 11'b000_0000_1000,
    S_SETUP = 11'b000_0001_0000,
    S_CHECK = 11'b000_0010_0000,
    S_RD    = 11'b000_0100_0000,
    S_WR    = 11'b000_1000_0000,
    S_NEXT  = 11'b001_0000_0000,
    S_RESRD = 11'b010_0000_0000,
    S_RESLD = 11'b100_0000_0000
  } state_e;

  state_e state_q;
  state_e state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          if (status_i.req_start) begin
            cmd_o.clear_init = 1'b1;
            state_d          = S_CLEAR;
          end else begin
            state_d = S_PLAN;
          end
        end
      end
      S_CLEAR: begin
        cmd_o.clear_step = 1'b1;
        if (status_i.clear_done) begin
          state_d = S_PLAN;
        end
      end
      S_PLAN: begin
        cmd_o.plan = 1'b1;
        state_d    = S_SETUP;
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        cmd_o.sweep_init = 1'b1;
        state_d          = status_i.chunk_skip ? S_NEXT : S_RD;
      end
      S_RD: begin
        cmd_o.sweep_rd = 1'b1;
        state_d        = S_WR;
      end
      S_WR: begin
        cmd_o.sweep_wr = 1'b1;
        state_d        = status_i.sweep_done ? S_NEXT : S_RD;
      end
      S_NEXT: begin
        if (status_i.chunk_last) begin
          state_d = S_RESRD;
        end else begin
          cmd_o.chunk_next = 1'b1;
          state_d          = S_SETUP;
        end
      end
      S_RESRD: begin
        cmd_o.res_rd = 1'b1;
        state_d      = S_RESLD;
      end
      S_RESLD: begin
        // Keep the read of the full-capacity entry going while the result
        // register is still occupied.
        cmd_o.res_rd = 1'b1;
        if (status_i.out_free) begin
          cmd_o.res_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // New requests are taken only between requests.
  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

// ----- dv/tb_bounded_knapsack_dp_top.sv -----
// ----------------------------------------------------------------------------
// Bounded knapsack DP testbench
// Drives item requests through the valid/stall channel and predicts every
// result with its own copy of the value table and the capacity register.
// A short table of directed requests comes first: extremes, boundaries, the
// zero-capacity and zero-cost cases. A run of heavy zero-cost items and
// random phases over several capacities follow. Both sides idle in random
// bursts, and the receiver holds off once for a long stretch so that the
// block backs up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bounded_knapsack_dp_top;

  localparam int RAND_ITEMS  = 60;
  localparam int CALM_ITEMS  = 20;
  localparam int SAT_ITEMS   = 10;
  localparam int HOLD_CYCLES = 20000;
  localparam int LIMIT_NS    = 50_000_000;

  // One row of the directed table. The result is typed in where it is obvious.
  typedef struct {
    logic [bkd_pkg::ADDR_W-1:0] cap;
    bkd_pkg::in_req_t           req;
    bit                         typed;
    bkd_pkg::out_res_t          want;
  } probe_row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  bkd_pkg::in_req_t           in_req_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  bkd_pkg::out_res_t          out_res_o;
  logic                       cfg_we_i;
  logic [bkd_pkg::ADDR_W-1:0] cfg_wdata_i;

  // Predictor state: the value table and the capacity in use.
  logic [31:0]                knap_tbl [0:bkd_pkg::MAX_CAPACITY];
  logic [bkd_pkg::ADDR_W-1:0] cap_model;

  bkd_pkg::out_res_t best_q [$];
  bkd_pkg::out_res_t head_res;
  int                fail_count = 0;
  bit                calm = 1'b0;
  bit                squeeze_pending = 1'b0;

  probe_row_t probe_tbl [23] = '{
    // Reset capacity of 20: count zero, unlimited fill, cost above capacity.
    '{10'd20,   '{1'b1, 10'd1,    16'd0,     8'd0},   1'b1, '{32'd0,        1'b0}},
    '{10'd20,   '{1'b0, 10'd1,    16'd5,     8'd255}, 1'b1, '{32'd100,      1'b1}},
    '{10'd20,   '{1'b1, 10'd1023, 16'd65535, 8'd255}, 1'b1, '{32'd0,        1'b1}},
    // Cost times count exactly at capacity, then just below it.
    '{10'd20,   '{1'b1, 10'd5,    16'd7,     8'd4},   1'b1, '{32'd28,       1'b1}},
    '{10'd20,   '{1'b1, 10'd5,    16'd7,     8'd3},   1'b1, '{32'd21,       1'b0}},
    // Zero cost adds each chunk value to every entry.
    '{10'd20,   '{1'b1, 10'd0,    16'd9,     8'd3},   1'b1, '{32'd27,       1'b0}},
    '{10'd20,   '{1'b0, 10'd0,    16'd65535, 8'd255}, 1'b0, '{32'd0,        1'b0}},
    '{10'd20,   '{1'b0, 10'd3,    16'd100,   8'd6},   1'b0, '{32'd0,        1'b0}},
    '{10'd20,   '{1'b0, 10'd7,    16'd50000, 8'd2},   1'b0, '{32'd0,        1'b0}},
    '{10'd20,   '{1'b1, 10'd2,    16'd11,    8'd9},   1'b0, '{32'd0,        1'b0}},
    '{10'd20,   '{1'b0, 10'd19,   16'd65535, 8'd1},   1'b0, '{32'd0,        1'b0}},
    '{10'd20,   '{1'b0, 10'd682,  16'd21845, 8'd170}, 1'b0, '{32'd0,        1'b0}},
    '{10'd20,   '{1'b0, 10'd341,  16'd43690, 8'd85},  1'b0, '{32'd0,        1'b0}},
    // Largest capacity.
    '{10'd1023, '{1'b1, 10'd1,    16'd65535, 8'd255}, 1'b1, '{32'd16711425, 1'b0}},
    '{10'd1023, '{1'b0, 10'd1023, 16'd65535, 8'd1},   1'b1, '{32'd16711425, 1'b1}},
    '{10'd1023, '{1'b0, 10'd4,    16'd3,     8'd255}, 1'b0, '{32'd0,        1'b0}},
    '{10'd1023, '{1'b1, 10'd37,   16'd1234,  8'd31},  1'b0, '{32'd0,        1'b0}},
    // Capacity zero: every request is unlimited, only a zero cost counts.
    '{10'd0,    '{1'b1, 10'd0,    16'd500,   8'd0},   1'b1, '{32'd500,      1'b1}},
    '{10'd0,    '{1'b0, 10'd5,    16'd65535, 8'd255}, 1'b1, '{32'd500,      1'b1}},
    '{10'd0,    '{1'b0, 10'd0,    16'd65535, 8'd0},   1'b1, '{32'd66035,    1'b1}},
    // Capacity one.
    '{10'd1,    '{1'b1, 10'd1,    16'd65535, 8'd0},   1'b1, '{32'd0,        1'b0}},
    '{10'd1,    '{1'b0, 10'd1,    16'd40000, 8'd1},   1'b1, '{32'd40000,    1'b1}},
    '{10'd1,    '{1'b0, 10'd0,    16'd1,     8'd3},   1'b1, '{32'd40003,    1'b0}}
  };

  bounded_knapsack_dp_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sum clipped to 32 bits.
  function automatic logic [31:0] sat_sum(logic [31:0] a, longint unsigned b);
    longint unsigned s;
    s = longint'(a) + b;
    return (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // One 0/1 pass for a chunk, sweeping the table downward.
  function automatic void sweep_down(int unsigned cap, longint unsigned step_cost,
                                     longint unsigned gain);
    int          v;
    logic [31:0] cand;
    if (step_cost > cap) return;
    for (v = cap; v >= int'(step_cost); v--) begin
      cand = sat_sum(knap_tbl[v - int'(step_cost)], gain);
      if (cand > knap_tbl[v]) knap_tbl[v] = cand;
    end
  endfunction

  // Applies one item request to the table and returns the result it gives.
  function automatic bkd_pkg::out_res_t knap_best_after(bkd_pkg::in_req_t r);
    int unsigned       cap;
    longint unsigned   chunk;
    longint unsigned   left;
    logic [31:0]       cand;
    int                v;
    bkd_pkg::out_res_t res;
    cap = cap_model;
    if (r.start_new) begin
      foreach (knap_tbl[i]) knap_tbl[i] = '0;
    end
    res.took_unlimited = (longint'(r.item_cost) * longint'(r.item_count)) >= cap;
    if (res.took_unlimited) begin
      // Complete pack: a single upward sweep.
      for (v = int'(r.item_cost); v <= int'(cap); v++) begin
        cand = sat_sum(knap_tbl[v - int'(r.item_cost)], r.item_value);
        if (cand > knap_tbl[v]) knap_tbl[v] = cand;
      end
    end else begin
      // Binary split of the count: chunks 1, 2, 4 and so on, then the rest.
      chunk = 1;
      left  = r.item_count;
      while (chunk < left) begin
        sweep_down(cap, chunk * r.item_cost, chunk * r.item_value);
        left  -= chunk;
        chunk <<= 1;
      end
      sweep_down(cap, left * r.item_cost, left * r.item_value);
    end
    res.best_value = knap_tbl[cap];
    return res;
  endfunction

  // Random item request; costs lean towards the capacity so the sweeps do work.
  function automatic bkd_pkg::in_req_t random_item(int unsigned cap);
    bkd_pkg::in_req_t r;
    r.start_new = ($urandom_range(0, 7) == 0);
    case ($urandom_range(0, 7))
      0: begin
        r.item_cost = '0;
      end
      1: begin
        r.item_cost = bkd_pkg::COST_W'($urandom_range(0, 1023));
      end
      default: begin
        r.item_cost = bkd_pkg::COST_W'($urandom_range(1, cap));
      end
    endcase
    r.item_value = bkd_pkg::VAL_W'($urandom_range(0, 65535));
    r.item_count = ($urandom_range(0, 3) == 0) ? bkd_pkg::CNT_W'($urandom_range(0, 255))
                                                : bkd_pkg::CNT_W'($urandom_range(0, 12));
    return r;
  endfunction

  // Offers one request, with an optional idle gap ahead of it, and records
  // the expected result once the block has taken it.
  task automatic offer_item(bkd_pkg::in_req_t req, bit typed, bkd_pkg::out_res_t want);
    int                gap;
    bkd_pkg::out_res_t calc;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_req_i   = req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    calc = knap_best_after(req);
    best_q.push_back(typed ? want : calc);
  endtask

  // Stops offering and waits until every expected result has come out.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (best_q.size() != 0) @(posedge clk_i);
  endtask

  // Writes the capacity register once the block has gone idle.
  task automatic set_capacity(logic [bkd_pkg::ADDR_W-1:0] cap);
    drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = cap;
    cap_model   = cap;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
  endtask

  // Result side: random stall bursts, one long hold-off on request, none
  // once the run has gone calm.
  initial begin
    out_stall_i = 1'b0;
    @(negedge clk_i);
    forever begin
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        out_stall_i     = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall_i     = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end else begin
        out_stall_i = 1'b0;
        repeat ($urandom_range(1, 15)) @(negedge clk_i);
      end
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (best_q.size() == 0) begin
        $error("result request with no expectation pending");
        fail_count++;
      end else begin
        head_res = best_q.pop_front();
        if (out_res_o.best_value !== head_res.best_value) begin
          $error("best_value: expected %0d, got %0d",
                 head_res.best_value, out_res_o.best_value);
          fail_count++;
        end
        if (out_res_o.took_unlimited !== head_res.took_unlimited) begin
          $error("took_unlimited: expected %0b, got %0b",
                 head_res.took_unlimited, out_res_o.took_unlimited);
          fail_count++;
        end
      end
    end
  end

  // Stimulus.
  initial begin
    int               rand_done;
    int               phase_len;
    bkd_pkg::in_req_t req;
    rand_done   = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    foreach (knap_tbl[i]) knap_tbl[i] = '0;
    cap_model = bkd_pkg::CAP_RESET;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table; the capacity changes between groups of rows.
    foreach (probe_tbl[i]) begin
      if (probe_tbl[i].cap != cap_model) set_capacity(probe_tbl[i].cap);
      offer_item(probe_tbl[i].req, probe_tbl[i].typed, probe_tbl[i].want);
    end

    // Still at capacity one: pile up heavy zero-cost items so the sums grow
    // large, then a few more random ones on the heavy table.
    for (int i = 0; i < SAT_ITEMS; i++) begin
      req = '{(i == 0), 10'd0, 16'hFFFF, 8'hFF};
      offer_item(req, 1'b0, '0);
    end
    repeat (10) begin
      req = random_item(cap_model);
      req.start_new = 1'b0;
      offer_item(req, 1'b0, '0);
    end

    // Random phases, each at its own capacity; the first one is squeezed
    // by a long hold-off on the result side, the last ones run calm.
    while (rand_done < RAND_ITEMS) begin
      phase_len = $urandom_range(8, 20);
      if (phase_len > RAND_ITEMS - rand_done) phase_len = RAND_ITEMS - rand_done;
      if ($urandom_range(0, 5) == 0) begin
        set_capacity(bkd_pkg::ADDR_W'($urandom_range(65, 300)));
      end else begin
        set_capacity(bkd_pkg::ADDR_W'($urandom_range(1, 64)));
      end
      if (rand_done == 0) squeeze_pending = 1'b1;
      calm = (rand_done >= RAND_ITEMS - CALM_ITEMS);
      repeat (phase_len) offer_item(random_item(cap_model), 1'b0, '0);
      rand_done += phase_len;
    end

    drain();
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #(LIMIT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- files.f -----
design/bkd_pkg.sv
design/bkd_ram.sv
design/bkd_datapath.sv
design/bkd_ctrl.sv
design/bounded_knapsack_dp_top.sv
dv/tb_bounded_knapsack_dp_top.sv
